FILE: rtl/bsd_pkg.sv
// shared types and constants for the base-216 line decoder
package bsd_pkg;

   localparam int unsigned LINE_DIGITS = 64;
   localparam int unsigned GROUP_BYTES = 4;

   typedef struct packed {
      logic [7:0] digit;
      logic [5:0] line_bytes;
   } req_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       last_of_run;
   } rsp_type;

   // bytes produced by one completed four-digit group
   typedef struct packed {
      logic [GROUP_BYTES-1:0][7:0] bytes;
      logic [2:0]                  count;
   } group_type;

   // weight of a digit by its place in the group, least significant first
   function automatic logic [23:0] radix_power(input logic [1:0] place);
      logic [23:0] weight;
      case (place)
         2'd0: weight = 24'd1;
         2'd1: weight = 24'd216;
         2'd2: weight = 24'd46656;
         2'd3: weight = 24'd10077696;
         default: weight = 24'd1;
      endcase
      return weight;
   endfunction

endpackage

FILE: rtl/bsd_group.sv
// line state, radix-216 word accumulation and byte cutting of one group
module bsd_group (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  bsd_pkg::req_type   item,
   output logic               group_end,
   output bsd_pkg::group_type group
);
   import bsd_pkg::*;

   logic [5:0]  pos_ff, pos_in;
   logic [30:0] word_ff, word_in;
   logic [6:0]  holder_ff, holder_in;
   logic [2:0]  held_ff, held_in;
   logic [5:0]  left_ff, left_in;

   logic [1:0]  place;
   logic [5:0]  left_cur;
   logic [30:0] word_base;
   logic [31:0] product;
   logic [30:0] word_new;
   logic [37:0] stream;
   logic [37:0] aligned;
   logic [2:0]  byte_cnt;
   logic [2:0]  emit_cnt;
   logic [7:0]  mask_wide;

   always_comb begin
      place     = pos_ff[1:0];
      group_end = (place == 2'd3);
      left_cur  = (pos_ff == 6'd0) ? item.line_bytes : left_ff;
      word_base = (place == 2'd0) ? 31'd0 : word_ff;
      product   = {24'd0, item.digit} * {8'd0, radix_power(place)};
      word_new  = 31'(word_base + product[30:0]);

      // held bits sit above the new word; align the oldest bit to the top
      stream    = {holder_ff, word_new};
      aligned   = stream << (3'd7 - held_ff);
      byte_cnt  = (held_ff == 3'd0) ? 3'd3 : 3'd4;
      emit_cnt  = (left_cur < {3'd0, byte_cnt}) ? left_cur[2:0] : byte_cnt;

      held_in   = held_ff;
      holder_in = holder_ff;
      word_in   = word_new;
      left_in   = left_cur;
      mask_wide = 8'd0;
      if (group_end) begin
         held_in   = held_ff - 3'd1;
         mask_wide = (8'd1 << held_in) - 8'd1;
         holder_in = word_new[6:0] & mask_wide[6:0];
         word_in   = 31'd0;
         left_in   = left_cur - {3'd0, emit_cnt};
      end
      pos_in = pos_ff + 6'd1;

      for (int k = 0; k < GROUP_BYTES; k++) begin
         group.bytes[k] = aligned[37 - 8*k -: 8];
      end
      group.count = group_end ? emit_cnt : 3'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= 6'd0;
         word_ff   <= 31'd0;
         holder_ff <= 7'd0;
         held_ff   <= 3'd0;
         left_ff   <= 6'd0;
      end else if (step) begin
         pos_ff    <= pos_in;
         word_ff   <= word_in;
         holder_ff <= holder_in;
         held_ff   <= held_in;
         left_ff   <= left_in;
      end
   end

endmodule

FILE: rtl/bsd_emit.sv
// result register: hands out the bytes of one group, one beat at a time
module bsd_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  bsd_pkg::group_type group,
   output logic               free,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output bsd_pkg::rsp_type   rsp_data
);
   import bsd_pkg::*;

   logic [GROUP_BYTES-1:0][7:0] bytes_ff;
   logic [2:0]                  rem_ff, rem_in;
   logic [1:0]                  idx_ff, idx_in;
   logic                        take;

   always_comb begin
      rsp_valid            = (rem_ff != 3'd0);
      take                 = rsp_valid && rsp_ready;
      free                 = (rem_ff == 3'd0) || ((rem_ff == 3'd1) && rsp_ready);
      rsp_data.byte_out    = bytes_ff[idx_ff];
      rsp_data.last_of_run = (rem_ff == 3'd1);

      rem_in = rem_ff;
      idx_in = idx_ff;
      if (load) begin
         rem_in = group.count;
         idx_in = 2'd0;
      end else if (take) begin
         rem_in = rem_ff - 3'd1;
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bytes_ff <= group.bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 3'd0;
         idx_ff <= 2'd0;
      end else begin
         rem_ff <= rem_in;
         idx_ff <= idx_in;
      end
   end

endmodule

FILE: rtl/base216_line_to_bytes.sv
// base-216 line decoder: 64 digits per line in, up to 62 bytes per line out
// a digit is held in the input register; a group-closing digit then loads its group's bytes into the result register
// throughput: one digit per cycle; a group-closing digit waits until the result
//    register is empty or is handing out the last byte of the previous group
// each group gives 3 or 4 bytes, fewer once the line's byte count runs out, one per output beat
// reset clears the line position, word, held bits and both valid flags
module base216_line_to_bytes (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bsd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bsd_pkg::rsp_type rsp_data
);
   import bsd_pkg::*;

   logic      in_vld_ff, in_vld_in;
   req_type   in_data_ff;
   logic      advance;
   logic      group_end;
   logic      emit_free;
   group_type group;

   // a group-closing digit needs the result register free
   assign advance   = in_vld_ff && (!group_end || emit_free);
   assign req_ready = !in_vld_ff || advance;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   bsd_group u_group (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item      (in_data_ff),
      .group_end (group_end),
      .group     (group)
   );

   bsd_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && group_end),
      .group     (group),
      .free      (emit_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
